// ----- rtl/bss_pkg.sv -----
// Shared types and codes for the bounded sorted set.
// Holds command codes, result status codes, controller state and handshake structs.
// No dependencies.
`default_nettype none

package bss_pkg;

  localparam int FUNC_W   = 2;
  localparam int ELEM_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } bss_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
  } bss_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_busy;
  } bss_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bss_ctrl.sv -----
// Controller state machine for the bounded sorted set.
// Sequences word capture and execution; depends on bss_pkg.
`default_nettype none

module bss_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  wire bss_pkg::bss_sts_t sts,
  output bss_pkg::bss_cmd_t  cmd
);

  bss_pkg::bss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      bss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = bss_pkg::S_EXEC;
        end
      end
      bss_pkg::S_EXEC: begin
        // hold until the result register can take the word
        if (!sts.out_busy) begin
          cmd.exec  = 1'b1;
          state_nxt = bss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/bss_dp.sv -----
// Datapath for the bounded sorted set: entry row, fill count, result register.
// Driven by bss_ctrl commands; depends on bss_pkg.
`default_nettype none

module bss_dp #(
  parameter int CAPACITY = 16
) (
  input  wire                        logic clk,
  input  wire                        logic rst_n,
  input  wire bss_pkg::bss_cmd_t     cmd,
  output bss_pkg::bss_sts_t          sts,
  input  wire logic [bss_pkg::FUNC_W-1:0]        in_func,
  input  wire logic signed [bss_pkg::ELEM_W-1:0] in_element,
  output logic                       out_valid,
  input  wire                        logic out_ready,
  output logic [bss_pkg::STATUS_W-1:0] out_status,
  output logic                       out_member,
  output logic [bss_pkg::COUNT_W-1:0] out_count,
  output logic                       out_full_res,
  output logic                       out_empty_res
);

  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > bss_pkg::COUNT_W) ? FW : bss_pkg::COUNT_W;

  logic [bss_pkg::FUNC_W-1:0]        func_r;
  logic signed [bss_pkg::ELEM_W-1:0] elem_r;
  logic signed [bss_pkg::ELEM_W-1:0] ent_r   [CAPACITY];
  logic signed [bss_pkg::ELEM_W-1:0] ent_ins [CAPACITY];
  logic signed [bss_pkg::ELEM_W-1:0] ent_rem [CAPACITY];
  logic [FW-1:0]                     fill_r, fill_nxt;
  logic [CAPACITY-1:0]               eq, lt;
  logic                              found, full_now, do_ins, do_rem;
  logic [bss_pkg::STATUS_W-1:0]      status;
  logic [CW-1:0]                     fill_ext;
  logic                              out_valid_r;
  logic [bss_pkg::STATUS_W-1:0]      status_r;
  logic                              member_r, full_r, empty_r;
  logic [bss_pkg::COUNT_W-1:0]       count_r;

  // capture the command word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      elem_r <= in_element;
    end
  end

  // per-slot compare and shift candidates
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic vld;
    assign vld   = (FW'(i) < fill_r);
    assign eq[i] = vld && (ent_r[i] == elem_r);
    assign lt[i] = vld && (ent_r[i] < elem_r);
    if (i == 0) begin : g_first
      assign ent_ins[i] = lt[i] ? ent_r[i] : elem_r;
    end else begin : g_rest
      assign ent_ins[i] = lt[i] ? ent_r[i] : (lt[i-1] ? elem_r : ent_r[i-1]);
    end
    if (i == CAPACITY - 1) begin : g_last
      assign ent_rem[i] = ent_r[i];
    end else begin : g_inner
      assign ent_rem[i] = lt[i] ? ent_r[i] : ent_r[i+1];
    end
  end

  assign found    = |eq;
  assign full_now = (fill_r == FW'(CAPACITY));
  assign do_ins   = (func_r == bss_pkg::FUNC_INSERT) && !found && !full_now;
  assign do_rem   = (func_r == bss_pkg::FUNC_REMOVE) && found;

  always_comb begin
    fill_nxt = fill_r;
    if (do_ins) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_rem) begin
      fill_nxt = fill_r - FW'(1);
    end
    case (func_r)
      bss_pkg::FUNC_INSERT: begin
        if (found) begin
          status = bss_pkg::ST_PRESENT;
        end else if (full_now) begin
          status = bss_pkg::ST_FULL;
        end else begin
          status = bss_pkg::ST_INSERTED;
        end
      end
      bss_pkg::FUNC_REMOVE: begin
        status = found ? bss_pkg::ST_REMOVED : bss_pkg::ST_ABSENT;
      end
      default: begin
        status = found ? bss_pkg::ST_FOUND : bss_pkg::ST_NOTFOUND;
      end
    endcase
  end

  assign fill_ext = CW'(fill_nxt);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < CAPACITY; k++) begin
        if (do_ins) begin
          ent_r[k] <= ent_ins[k];
        end else if (do_rem) begin
          ent_r[k] <= ent_rem[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        fill_r <= fill_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status;
      member_r <= found;
      count_r  <= fill_ext[bss_pkg::COUNT_W-1:0];
      full_r   <= (fill_nxt == FW'(CAPACITY));
      empty_r  <= (fill_nxt == '0);
    end
  end

  assign sts.out_busy  = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_member    = member_r;
  assign out_count     = count_r;
  assign out_full_res  = full_r;
  assign out_empty_res = empty_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(CAPACITY))
    else $error("fill count above capacity");

  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(fill_r))
    else $error("fill count moved without an executed word");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten before it was taken");

  a_result_up: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed word produced no result");

endmodule

`default_nettype wire

// ----- rtl/bounded_sorted_set.sv -----
// Bounded sorted set: top level joining bss_ctrl and bss_dp; depends on bss_pkg.
// The result word is registered at the execute step, which follows the capture of the word.
// A new word is accepted only after the execute step of the previous one, as the controller
// sequences capture and execute; a waiting result stalls the execute step until the consumer
// takes it.
// Reset (rst_n low, synchronous): the set is emptied and no result is pending.
`default_nettype none

module bounded_sorted_set #(
  parameter int CAPACITY = 16
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic in_ready,
  input  wire  logic [bss_pkg::FUNC_W-1:0]        in_func,
  input  wire  logic signed [bss_pkg::ELEM_W-1:0] in_element,
  output logic out_valid,
  input  wire  logic out_ready,
  output logic [bss_pkg::STATUS_W-1:0] out_status,
  output logic out_member,
  output logic [bss_pkg::COUNT_W-1:0]  out_count,
  output logic out_full_res,
  output logic out_empty_res
);

  // Command path: controller captures a word, then orders one execute step.
  bss_pkg::bss_cmd_t cmd;
  // Status path: datapath reports a result still waiting to be taken.
  bss_pkg::bss_sts_t sts;

  bss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entries sit in a row of registers kept sorted; every slot is compared with
  // the element at once, and insert/remove shift the entries from the element's position onward in one step.
  bss_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_func),
    .in_element    (in_element),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_member    (out_member),
    .out_count     (out_count),
    .out_full_res  (out_full_res),
    .out_empty_res (out_empty_res)
  );

endmodule

`default_nettype wire
